[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the stereo view warp.
// Depends on nothing; files that check take it by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define DSVW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define DSVW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DSVW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define DSVW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/core/dsvw_pkg.sv]
// Shared types, constants and codes of the stereo view warp.
// Depends on nothing; used by every other file of the block but dsvw_ram and assert_macros.svh.
package dsvw_pkg;

	// line geometry
	localparam int MAX_WIDTH  = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int WID_W      = COL_W + 1;
	localparam int LINE_DEPTH = 2 * MAX_WIDTH;
	localparam int ADDR_W     = $clog2(LINE_DEPTH);
	localparam int OUTCOL_W   = 10;

	// pixel and depth fields
	localparam int CH_W     = 8;
	localparam int COLOUR_W = 3 * CH_W;
	localparam int DEPTH_W  = 16;
	localparam int DVS_W    = DEPTH_W - 1;

	// configuration
	localparam int FB_W        = 32;
	localparam int RW_W        = 11;
	localparam int DEPTH_SHIFT = 8;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;
	localparam logic [FB_W-1:0] FB_RESET = FB_W'(7680000);
	localparam logic [RW_W-1:0] RW_RESET = RW_W'(640);

	// register index codes (paddr bit above the word offset)
	localparam logic REG_FOCAL = 1'b0;
	localparam logic REG_WIDTH = 1'b1;

	// divider: (focal_baseline >> 8) / depth
	localparam int DVD_W     = FB_W - DEPTH_SHIFT;
	localparam int DIV_STEPS = DVD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// classified word handed from front to back
	typedef struct packed {
		logic [COLOUR_W-1:0] colour;
		logic [DVS_W-1:0]    depth;
		logic                depth_ok;
		logic [COL_W-1:0]    col;
		logic                last;
		logic                wbank;
	} pix_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [2:0] {
		BK_SWEEP,
		BK_IDLE,
		BK_READ,
		BK_CLEAR,
		BK_DIV,
		BK_WRITE,
		BK_EMIT
	} back_state_t;

endpackage

[rtl/core/dsvw_if.sv]
// Stream interfaces of the stereo view warp: left pixels in, right pixels out.
// Depends on dsvw_pkg.
interface dsvw_pix_if;
	import dsvw_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CH_W-1:0]      blue;
	logic [CH_W-1:0]      green;
	logic [CH_W-1:0]      red;
	logic [DEPTH_W-1:0]   depth;
	logic                 frame_start;

	modport source (output valid, blue, green, red, depth, frame_start, input ready);
	modport sink (input valid, blue, green, red, depth, frame_start, output ready);
endinterface

interface dsvw_res_if;
	import dsvw_pkg::*;
	logic                valid;
	logic                ready;
	logic [CH_W-1:0]     out_blue;
	logic [CH_W-1:0]     out_green;
	logic [CH_W-1:0]     out_red;
	logic [OUTCOL_W-1:0] out_column;
	logic                row_last;

	modport source (output valid, out_blue, out_green, out_red, out_column, row_last,
		input ready);
	modport sink (input valid, out_blue, out_green, out_red, out_column, row_last,
		output ready);
endinterface

[rtl/core/dsvw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module dsvw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/dsvw_div.sv]
// Radix-2 restoring divider for the disparity, one quotient bit a cycle.
// Depends on dsvw_pkg.
module dsvw_div (
	input  logic               clk,
	input  logic               arst_n,
	input  dsvw_pkg::div_req_t req,
	output dsvw_pkg::div_rsp_t rsp
);
	import dsvw_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVD_W-1:0]     quo_q;
	logic [DVS_W-1:0]     dvs_q;

	logic [DVS_W:0] trial;
	logic [DVS_W:0] diff;
	logic           ge;

	// one trial subtraction per step
	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

[rtl/core/dsvw_front.sv]
// Front of the warp: takes pixels, tracks column and bank, classifies depth.
// Depends on dsvw_pkg and dsvw_pix_if.
module dsvw_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [dsvw_pkg::RW_W-1:0] row_width,
	input  logic                   enable,
	input  dsvw_pkg::q_stat_t      q_stat,
	dsvw_pix_if.sink               pix,
	output logic                   q_push,
	output dsvw_pkg::pix_entry_t   q_data
);
	import dsvw_pkg::*;

	logic [COL_W-1:0] column_count_q;
	logic             write_bank_q;

	logic [WID_W-1:0] w;
	logic [COL_W-1:0] col_raw;
	logic [COL_W-1:0] col;
	logic [COL_W-1:0] w_m1;
	logic             last;

	// width in use: zero reads as one, large values saturate
	always_comb begin
		priority if (row_width == '0) begin
			w = WID_W'(1);
		end else if (int'(row_width) > MAX_WIDTH) begin
			w = WID_W'(MAX_WIDTH);
		end else begin
			w = WID_W'(row_width);
		end
	end

	// column of this word, clipped to the last column
	assign w_m1    = COL_W'(w - 1'b1);
	assign col_raw = pix.frame_start ? '0 : column_count_q;
	assign col     = ({1'b0, col_raw} >= w) ? w_m1 : col_raw;
	assign last    = (col == w_m1);

	// handshake
	assign pix.ready = enable && !q_stat.full;
	assign q_push    = pix.valid && pix.ready;

	// classified word
	always_comb begin
		q_data.colour   = {pix.red, pix.green, pix.blue};
		q_data.depth    = pix.depth[DVS_W-1:0];
		q_data.depth_ok = !pix.depth[DEPTH_W-1] && (pix.depth != '0);
		q_data.col      = col;
		q_data.last     = last;
		q_data.wbank    = write_bank_q;
	end

	// column counter and bank toggle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			write_bank_q   <= 1'b0;
		end else if (q_push) begin
			if (last) begin
				column_count_q <= '0;
				write_bank_q   <= !write_bank_q;
			end else begin
				column_count_q <= col + 1'b1;
			end
		end
	end

endmodule

[rtl/core/dsvw_queue.sv]
// Short FIFO of classified words between front and back.
// Depends on dsvw_pkg.
module dsvw_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  dsvw_pkg::pix_entry_t push_data,
	input  logic                 pop,
	output dsvw_pkg::pix_entry_t pop_data,
	output dsvw_pkg::q_stat_t    stat
);
	import dsvw_pkg::*;

	pix_entry_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data   = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);

endmodule

[rtl/core/dsvw_back.sv]
// Back of the warp: line store read-clear, disparity divide, warped write, output.
// Depends on dsvw_pkg, dsvw_res_if, dsvw_div and dsvw_ram.
module dsvw_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [dsvw_pkg::FB_W-1:0] focal_baseline,
	input  dsvw_pkg::q_stat_t         q_stat,
	input  dsvw_pkg::pix_entry_t      q_data,
	output logic                      q_pop,
	output logic                      sweep_done,
	dsvw_res_if.source                res
);
	import dsvw_pkg::*;

	back_state_t         state_q;
	back_state_t         state_d;
	logic [ADDR_W-1:0]   sweep_q;
	pix_entry_t          cur_q;
	logic [COLOUR_W-1:0] px_q;

	logic                out_vld_q;
	logic [CH_W-1:0]     out_blue_q;
	logic [CH_W-1:0]     out_green_q;
	logic [CH_W-1:0]     out_red_q;
	logic [OUTCOL_W-1:0] out_column_q;
	logic                row_last_q;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [COLOUR_W-1:0] ram_wdata;
	logic                ram_re;
	logic [COLOUR_W-1:0] ram_rdata;
	logic [ADDR_W-1:0]   rd_addr;
	logic                load_out;

	div_req_t            div_req;
	div_rsp_t            div_rsp;
	logic                div_start;
	logic                hit;
	logic [COL_W-1:0]    tgt;

	dsvw_ram #(
		.WIDTH (COLOUR_W),
		.DEPTH (LINE_DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	dsvw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// finished row sits in the other bank
	assign rd_addr = {!cur_q.wbank, cur_q.col};

	// target column of the warped write
	assign hit = div_rsp.quotient <= DVD_W'(cur_q.col);
	assign tgt = cur_q.col - div_rsp.quotient[COL_W-1:0];

	assign div_req.start    = div_start;
	assign div_req.dividend = focal_baseline[FB_W-1:DEPTH_SHIFT];
	assign div_req.divisor  = cur_q.depth;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_SWEEP: begin
				if (sweep_q == ADDR_W'(LINE_DEPTH - 1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (!q_stat.empty) begin
					state_d = BK_READ;
				end
			end
			BK_READ:  state_d = BK_CLEAR;
			BK_CLEAR: state_d = BK_DIV;
			BK_DIV: begin
				if (div_rsp.done) begin
					state_d = BK_WRITE;
				end
			end
			BK_WRITE: state_d = BK_EMIT;
			BK_EMIT: begin
				if (!out_vld_q || res.ready) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_SWEEP;
		endcase
	end

	// state outputs
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rd_addr;
		ram_wdata = '0;
		ram_re    = 1'b0;
		q_pop     = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			BK_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = sweep_q;
			end
			BK_IDLE: begin
				q_pop = !q_stat.empty;
			end
			BK_READ: begin
				ram_re    = 1'b1;
				div_start = 1'b1;
			end
			BK_CLEAR: begin
				ram_we = 1'b1;
			end
			BK_DIV: begin
			end
			BK_WRITE: begin
				ram_we    = cur_q.depth_ok && hit;
				ram_waddr = {cur_q.wbank, tgt};
				ram_wdata = cur_q.colour;
			end
			BK_EMIT: begin
				load_out = !out_vld_q || res.ready;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_SWEEP;
			sweep_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_SWEEP) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
		if (state_q == BK_CLEAR) begin
			px_q <= ram_rdata;
		end
		if (load_out) begin
			out_blue_q   <= px_q[CH_W-1:0];
			out_green_q  <= px_q[2*CH_W-1:CH_W];
			out_red_q    <= px_q[3*CH_W-1:2*CH_W];
			out_column_q <= OUTCOL_W'(cur_q.col);
			row_last_q   <= cur_q.last;
		end
	end

	assign sweep_done     = (state_q != BK_SWEEP);
	assign res.valid      = out_vld_q;
	assign res.out_blue   = out_blue_q;
	assign res.out_green  = out_green_q;
	assign res.out_red    = out_red_q;
	assign res.out_column = out_column_q;
	assign res.row_last   = row_last_q;

endmodule

[rtl/core/depth_to_stereo_view_warp.sv]
// Top level of the depth-based stereo view warp: APB registers, front, queue, back.
// Depends on dsvw_pkg, dsvw_if, dsvw_front, dsvw_queue, dsvw_back, assert_macros.svh.
//
//   channel  dir  handshake            word
//   pix      in   valid/ready          blue, green, red, depth, frame_start
//   res      out  valid/ready          out_blue, out_green, out_red, out_column, row_last
//   apb      in   psel/penable/pready  focal_baseline at 0x0, row_width at 0x4
//
// In the back end a word goes through the line-store read, the clear, the 24-step
// disparity divider, the warped write and the output load.
// After reset the line store is cleared, one entry a cycle; pix.ready stays low until then.
// Registers may be written during that pass.
// The front takes up to two words ahead into its queue while the back is busy or the
// output register waits on res.ready.
module depth_to_stereo_view_warp (
	input  logic                         clk,
	input  logic                         arst_n,
	dsvw_pix_if.sink                     pix,
	dsvw_res_if.source                   res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dsvw_pkg::PADDR_W-1:0] paddr,
	input  logic [dsvw_pkg::PDATA_W-1:0] pwdata,
	output logic [dsvw_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import dsvw_pkg::*;

`include "assert_macros.svh"

	logic [FB_W-1:0] focal_baseline_q;
	logic [RW_W-1:0] row_width_q;
	logic            cfg_wr;

	logic            q_push;
	logic            q_pop;
	pix_entry_t      q_in;
	pix_entry_t      q_out;
	q_stat_t         q_stat;
	logic            sweep_done;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_baseline_q <= FB_RESET;
			row_width_q      <= RW_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[PADDR_W-1])
				REG_FOCAL: focal_baseline_q <= pwdata[FB_W-1:0];
				REG_WIDTH: row_width_q      <= pwdata[RW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[PADDR_W-1])
			REG_FOCAL: prdata = PDATA_W'(focal_baseline_q);
			REG_WIDTH: prdata = PDATA_W'(row_width_q);
			default:   prdata = '0;
		endcase
	end

	dsvw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.row_width (row_width_q),
		.enable    (sweep_done),
		.q_stat    (q_stat),
		.pix       (pix),
		.q_push    (q_push),
		.q_data    (q_in)
	);

	dsvw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.pop_data  (q_out),
		.stat      (q_stat)
	);

	dsvw_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.focal_baseline (focal_baseline_q),
		.q_stat         (q_stat),
		.q_data         (q_out),
		.q_pop          (q_pop),
		.sweep_done     (sweep_done),
		.res            (res)
	);

	// checks
	`DSVW_ASSERT_IMP(a_push_room, clk, arst_n, q_push, !q_stat.full, "push into full queue")
	`DSVW_ASSERT_IMP(a_pop_data, clk, arst_n, q_pop, !q_stat.empty, "pop from empty queue")
	`DSVW_ASSERT_NXT(a_push_seen, clk, arst_n, q_push && q_stat.empty, !q_stat.empty,
		"queue empty after push")
	`DSVW_ASSERT_IMP(a_sweep_block, clk, arst_n, !sweep_done, !pix.ready,
		"word taken during line store clear")

endmodule

[tb/stereo_warp_check.sv]
// Watcher of the stereo view warp: follows the pixel, result and register ports, works out
// every right-eye word from its own copy of the line store and compares it with the block.
// Depends on dsvw_pkg and the stream interfaces in dsvw_if.
module stereo_warp_check
	import dsvw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	dsvw_pix_if                pix,
	dsvw_res_if                res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic [PDATA_W-1:0] prdata,
	output int                 errors,
	output int                 pending,
	output int                 pix_seen,
	output int                 res_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [CH_W-1:0]     blue;
		logic [CH_W-1:0]     green;
		logic [CH_W-1:0]     red;
		logic [OUTCOL_W-1:0] column;
		logic                row_last;
	} right_px_t;

	// own copy of registers and line store
	logic [FB_W-1:0]     focal_q;
	logic [RW_W-1:0]     width_q;
	logic [COLOUR_W-1:0] line_mem [LINE_DEPTH];
	logic                build_bank;
	int unsigned         next_col;
	right_px_t           right_px_due [$];
	int                  err_q;
	int                  in_q;
	int                  out_q;

	initial begin
		err_q = 0;
		in_q  = 0;
		out_q = 0;
	end

	// one left pixel: emit the previous row at this column, clear it, warp into the new row
	function automatic right_px_t warp_pixel(input logic [COLOUR_W-1:0] colour,
		input logic [DEPTH_W-1:0] depth, input logic frame_start);
		int unsigned w;
		int unsigned col;
		logic [63:0] disp;
		logic [COLOUR_W-1:0] px;
		right_px_t word;
		w = width_q;
		if (w == 0)
			w = 1;
		if (w > MAX_WIDTH)
			w = MAX_WIDTH;
		col = frame_start ? 0 : next_col;
		if (col >= w)
			col = w - 1;
		word.row_last = (col == w - 1);
		px = line_mem[{~build_bank, COL_W'(col)}];
		line_mem[{~build_bank, COL_W'(col)}] = '0;
		// top bit set reads as a negative depth
		if (depth != 0 && !depth[DEPTH_W-1]) begin
			disp = 64'(focal_q) / (64'(depth) << DEPTH_SHIFT);
			if (disp <= 64'(col))
				line_mem[{build_bank, COL_W'(col - int'(disp))}] = colour;
		end
		word.blue   = px[CH_W-1:0];
		word.green  = px[2*CH_W-1:CH_W];
		word.red    = px[3*CH_W-1:2*CH_W];
		word.column = OUTCOL_W'(col);
		if (word.row_last) begin
			build_bank = ~build_bank;
			next_col   = 0;
		end else begin
			next_col = col + 1;
		end
		return word;
	endfunction

	task automatic check_field(input string what, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0h actual %0h", $time, what, want, got);
			err_q++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_q    = FB_RESET;
			width_q    = RW_RESET;
			build_bank = 1'b0;
			next_col   = 0;
			foreach (line_mem[i])
				line_mem[i] = '0;
			right_px_due.delete();
		end else begin
			// right-eye word leaving the block
			if (res.valid && res.ready) begin
				out_q++;
				if (right_px_due.size() == 0) begin
					$display("%0t: right-eye word with none due, expected nothing actual col %0d",
						$time, res.out_column);
					err_q++;
				end else begin
					right_px_t want;
					want = right_px_due.pop_front();
					check_field("out_blue", want.blue, res.out_blue);
					check_field("out_green", want.green, res.out_green);
					check_field("out_red", want.red, res.out_red);
					check_field("out_column", want.column, res.out_column);
					check_field("row_last", want.row_last, res.row_last);
				end
			end
			// left pixel word entering the block
			if (pix.valid && pix.ready) begin
				in_q++;
				right_px_due.insert(right_px_due.size(),
					warp_pixel({pix.red, pix.green, pix.blue}, pix.depth, pix.frame_start));
			end
			// register access, write or read back
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[PADDR_W-1])
						REG_FOCAL: focal_q = pwdata[FB_W-1:0];
						REG_WIDTH: width_q = pwdata[RW_W-1:0];
					endcase
				end else begin
					check_field("prdata", (paddr[PADDR_W-1] == REG_FOCAL) ?
						32'(focal_q) : 32'(width_q), prdata);
				end
			end
		end
		errors   <= err_q;
		pending  <= right_px_due.size();
		pix_seen <= in_q;
		res_seen <= out_q;
	end

endmodule

[tb/testbench.sv]
// Top of the stereo view warp bench: clock, reset, register setup and pixel stimulus,
// with the block and its watcher side by side.
// Depends on dsvw_pkg, dsvw_if, depth_to_stereo_view_warp and stereo_warp_check.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import dsvw_pkg::*;

	localparam int PERIOD       = 8;
	localparam int IDLE_LIMIT   = 20000;
	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES = 64;
	localparam int RANDOM_ITEMS = 360;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int errors;
	int pending;
	int pix_seen;
	int res_seen;
	int settings;
	int quiet = 0;
	bit tight_send;
	bit hold_req;

	dsvw_pix_if pix ();
	dsvw_res_if res ();

	depth_to_stereo_view_warp dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix     (pix),
		.res     (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	stereo_warp_check check_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix      (pix),
		.res      (res),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.pready   (pready),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.errors   (errors),
		.pending  (pending),
		.pix_seen (pix_seen),
		.res_seen (res_seen)
	);

	always #(PERIOD / 2) clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 88)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// depths lean toward small values so disparities stay within short rows
	function automatic logic [DEPTH_W-1:0] pick_depth();
		int p;
		p = $urandom_range(0, 99);
		if (p < 12)
			return '0;
		if (p < 20)
			return 16'h8000 | 16'($urandom);
		if (p < 65)
			return 16'($urandom_range(1, 48));
		if (p < 85)
			return 16'($urandom_range(1, 1024));
		return 16'($urandom_range(1, 32767));
	endfunction

	// one APB access, then the bus goes idle
	task automatic reg_access(input logic write, input logic idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_warp(input logic [31:0] focal, input logic [RW_W-1:0] width);
		reg_access(1'b1, REG_FOCAL, focal);
		reg_access(1'b1, REG_WIDTH, 32'(width));
		reg_access(1'b0, REG_FOCAL, '0);
		reg_access(1'b0, REG_WIDTH, '0);
		settings++;
	endtask

	// offer one left pixel word and hold it until taken
	task automatic send_pixel(input logic [COLOUR_W-1:0] colour,
		input logic [DEPTH_W-1:0] depth, input logic frame_start);
		int gap;
		gap = tight_send ? 0 : idle_len();
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix.valid       <= 1'b1;
		pix.blue        <= colour[CH_W-1:0];
		pix.green       <= colour[2*CH_W-1:CH_W];
		pix.red         <= colour[3*CH_W-1:2*CH_W];
		pix.depth       <= depth;
		pix.frame_start <= frame_start;
		do @(posedge clk); while (!pix.ready);
	endtask

	// raster rows with random content; noisy streams flip frame starts now and then
	task automatic send_rows(input int items, input int width, input bit noisy);
		int col;
		int w;
		logic fs;
		w = (width == 0) ? 1 : ((width > MAX_WIDTH) ? MAX_WIDTH : width);
		col = 0;
		for (int i = 0; i < items; i++) begin
			if (i == 0)
				fs = ($urandom_range(0, 3) != 0);
			else
				fs = (col == 0) && ($urandom_range(0, 3) == 0);
			if (noisy && $urandom_range(0, 15) == 0)
				fs = ~fs;
			send_pixel(24'($urandom), pick_depth(), fs);
			if (fs)
				col = 0;
			col = (col >= w - 1) ? 0 : col + 1;
		end
	endtask

	// stop offering and wait for every due word to come out
	task automatic drain();
		pix.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin : receiver
		int stall;
		int run;
		bit held;
		held = 1'b0;
		res.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !held) begin
				held  = 1'b1;
				stall = HOLD_CYCLES;
			end else begin
				stall = ($urandom_range(0, 4) == 0) ? 0 : idle_len();
			end
			if (stall > 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res.ready <= 1'b1;
			run = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
			repeat (run) @(posedge clk);
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((pix.valid && pix.ready) || (res.valid && res.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= IDLE_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : stimulus
		int sent;
		int phase;
		int width;
		int items;
		int p;
		logic [31:0] focal;
		bit noisy;
		settings   = 0;
		tight_send = 1'b0;
		hold_req   = 1'b0;
		arst_n          <= 1'b0;
		psel            <= 1'b0;
		penable         <= 1'b0;
		pwrite          <= 1'b0;
		paddr           <= '0;
		pwdata          <= '0;
		pix.valid       <= 1'b0;
		pix.blue        <= '0;
		pix.green       <= '0;
		pix.red         <= '0;
		pix.depth       <= '0;
		pix.frame_start <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, read during the clearing pass
		reg_access(1'b0, REG_FOCAL, '0);
		reg_access(1'b0, REG_WIDTH, '0);

		// four-pixel rows, disparity 3/depth
		set_warp(32'd768, 4);
		send_pixel(24'hFFFFFF, 16'd1, 1'b1);     // disparity past column 0: dropped
		send_pixel(24'hFFFFFF, 16'd2, 1'b0);     // lands on column 0
		send_pixel(24'h00FF00, 16'd0, 1'b0);     // no depth
		send_pixel(24'h0000FF, 16'd3, 1'b0);
		send_pixel(24'h000000, 16'd32767, 1'b0); // zero disparity
		send_pixel(24'hA5A5A5, 16'h8000, 1'b0);  // negative depth
		send_pixel(24'h5A5A5A, 16'hFFFF, 1'b0);
		send_pixel(24'h123456, 16'd4, 1'b0);
		send_pixel(24'hFF00FF, 16'd1, 1'b0);
		send_pixel(24'h00FFFF, 16'd8, 1'b0);
		send_pixel(24'h808080, 16'd2, 1'b1);     // frame restart in mid-row
		repeat (4) send_pixel(24'($urandom), 16'd0, 1'b0);
		drain();

		// width shrinks below the column count in mid-row
		set_warp(FB_RESET, 64);
		repeat (6) send_pixel(24'($urandom), 16'($urandom_range(1, 32767)), 1'b0);
		drain();
		set_warp(32'd512, 3);
		repeat (3) send_pixel(24'($urandom), 16'($urandom_range(1, 3)), 1'b0);
		drain();

		// width zero acts as one column
		set_warp(32'd256, 0);
		repeat (3) send_pixel(24'($urandom), 16'd1, 1'b0);
		drain();

		// random settings, mostly short rows
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			p = $urandom_range(0, 99);
			if (p < 70)
				width = $urandom_range(1, 24);
			else if (p < 85)
				width = $urandom_range(25, 100);
			else
				width = $urandom_range(101, 2047);
			p = $urandom_range(0, 99);
			if (p < 8)
				focal = '0;
			else if (p < 14)
				focal = '1;
			else if (p < 20)
				focal = $urandom;
			else
				focal = (32'($urandom_range(0, 48 * width)) << DEPTH_SHIFT) |
					32'($urandom_range(0, 255));
			if (width <= 24)
				items = width * $urandom_range(2, 8);
			else if (width <= 100)
				items = width * 2;
			else
				items = $urandom_range(20, 40);
			tight_send = ($urandom_range(0, 3) == 0);
			noisy      = ($urandom_range(0, 4) == 0);
			// back-pressure run: sender keeps offering while the output is held off
			if (phase == 1) begin
				hold_req   = 1'b1;
				tight_send = 1'b1;
				if (items < 80)
					items = 80;
			end
			set_warp(focal, width);
			send_rows(items, width, noisy);
			drain();
			sent += items;
			phase++;
		end

		// one full row at the saturated width, then two short rows
		tight_send = 1'b0;
		set_warp((32'($urandom_range(0, 3000)) << DEPTH_SHIFT), 2047);
		send_rows(MAX_WIDTH, 2047, 1'b0);
		drain();
		set_warp(32'd2048, 8);
		send_rows(16, 8, 1'b0);
		drain();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("tb: %0d left pixels in, %0d right-eye words checked, %0d register settings",
			pix_seen, res_seen, settings);
		if (errors == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
